[hw/rtl/krt_pkg.sv]
// ----------------------------------------------------------------------------
// krt_pkg: shared types and codes of the keyed record table
// Command and status codes, the record layout and the result bundle that
// the sequencer hands to the output register.
// ----------------------------------------------------------------------------
package krt_pkg;

    // Default table depth.
    localparam int DEF_ENTRIES = 64;

    // Field widths.
    localparam int ID_W    = 16;
    localparam int TEAM_W  = 8;
    localparam int GOAL_W  = 8;
    localparam int COUNT_W = 7;

    // Largest id; the counter saturates here.
    localparam logic [ID_W-1:0] ID_MAX = '1;

    // Command codes.
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_LOOKUP = 3'd2;
    localparam logic [2:0] CMD_UPDATE = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    // Status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // One stored record.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TEAM_W-1:0] team_a;
        logic [TEAM_W-1:0] team_b;
        logic [GOAL_W-1:0] goals_a;
        logic [GOAL_W-1:0] goals_b;
    } t_rec;

    // One finished result item.
    typedef struct packed {
        logic [1:0]         status;
        t_rec               rec;
        logic [COUNT_W-1:0] entry_count;
        logic [ID_W-1:0]    next_free_id;
    } t_result;

endpackage

[hw/rtl/keyed_record_table.sv]
// Insert, load and unknown commands go from idle straight to the result state.
// Lookup, update and remove search with one id compare per cycle from the newest record.
// Remove then moves each newer record down one slot, none when the newest one goes.
// Throughput: one item at a time; stall stays high until the result enters the output register.
// Reset clears the record count and the id counter; records are undefined until written.
// ----------------------------------------------------------------------------
// keyed_record_table: table of records keyed by id
// Insert, load, lookup, update and remove on up to ENTRIES records, with a
// registered result item toward the consumer.
// ----------------------------------------------------------------------------
module keyed_record_table #(
    parameter int ENTRIES = krt_pkg::DEF_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input items
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_cmd,
    input  logic [15:0]       i_match_id,
    input  logic [7:0]        i_team_a,
    input  logic [7:0]        i_team_b,
    input  logic signed [8:0] i_goals_a,
    input  logic signed [8:0] i_goals_b,
    // Result items
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [15:0]       o_out_id,
    output logic [7:0]        o_out_team_a,
    output logic [7:0]        o_out_team_b,
    output logic [7:0]        o_out_goals_a,
    output logic [7:0]        o_out_goals_b,
    output logic [6:0]        o_entry_count,
    output logic [15:0]       o_next_free_id
);
    import krt_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_rec          wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_rec          rd_data;
    logic          res_valid;
    logic          res_take;
    t_result       res;

    logic          r_ov;
    t_result       r_out;

    // Record memory.
    krt_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Command sequencer.
    krt_seq #(
        .ENTRIES (ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_match_id  (i_match_id),
        .i_team_a    (i_team_a),
        .i_team_b    (i_team_b),
        .i_goals_a   (i_goals_a),
        .i_goals_b   (i_goals_b),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // The output register takes a result when empty or being emptied.
    assign res_take = res_valid && (!r_ov || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_take) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_out.status;
    assign o_out_id       = r_out.rec.id;
    assign o_out_team_a   = r_out.rec.team_a;
    assign o_out_team_b   = r_out.rec.team_b;
    assign o_out_goals_a  = r_out.rec.goals_a;
    assign o_out_goals_b  = r_out.rec.goals_b;
    assign o_entry_count  = r_out.entry_count;
    assign o_next_free_id = r_out.next_free_id;

endmodule

[hw/rtl/krt_store.sv]
// ----------------------------------------------------------------------------
// krt_store: record memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krt_store #(
    parameter int ENTRIES = krt_pkg::DEF_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  krt_pkg::t_rec              i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output krt_pkg::t_rec              o_rd_data
);
    import krt_pkg::*;

    t_rec r_mem [ENTRIES];
    t_rec r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/krt_seq.sv]
// ----------------------------------------------------------------------------
// krt_seq: command sequencer
// Appends records, walks the table from newest to oldest with one id
// compare per cycle, rewrites goal counts and closes the gap after removal.
// ----------------------------------------------------------------------------
module krt_seq #(
    parameter int ENTRIES = krt_pkg::DEF_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input items
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_cmd,
    input  logic [15:0]                i_match_id,
    input  logic [7:0]                 i_team_a,
    input  logic [7:0]                 i_team_b,
    input  logic signed [8:0]          i_goals_a,
    input  logic signed [8:0]          i_goals_b,
    // Finished result toward the output register
    output logic                       o_res_valid,
    input  logic                       i_res_take,
    output krt_pkg::t_result           o_res,
    // Record memory
    output logic                       o_wr_en,
    output logic [$clog2(ENTRIES)-1:0] o_wr_addr,
    output krt_pkg::t_rec              o_wr_data,
    output logic                       o_rd_en,
    output logic [$clog2(ENTRIES)-1:0] o_rd_addr,
    input  krt_pkg::t_rec              i_rd_data
);
    import krt_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SRCH  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [ID_W-1:0]   r_mid, n_mid;
    logic signed [8:0] r_ga, n_ga;
    logic signed [8:0] r_gb, n_gb;
    logic [CW-1:0]     r_held, n_held;
    logic [ID_W-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_cv, n_cv;
    logic [AW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_src, n_src;
    logic              r_wv, n_wv;
    logic [AW-1:0]     r_dst, n_dst;
    logic [1:0]        r_status, n_status;
    t_rec              r_rec, n_rec;

    logic [CW-1:0]      idx_m1;
    logic [AW-1:0]      src_m1;
    logic [ID_W-1:0]    new_id;
    t_rec               new_rec;
    t_rec               upd_rec;
    logic [COUNT_W-1:0] count_out;

    assign idx_m1 = r_idx - 1'b1;
    assign src_m1 = r_src[AW-1:0] - 1'b1;

    // Record built from the input item for insert and load.
    always_comb begin
        new_id          = (i_cmd == CMD_INSERT) ? r_cnt : i_match_id;
        new_rec.id      = new_id;
        new_rec.team_a  = i_team_a;
        new_rec.team_b  = i_team_b;
        new_rec.goals_a = i_goals_a[8] ? '0 : i_goals_a[7:0];
        new_rec.goals_b = i_goals_b[8] ? '0 : i_goals_b[7:0];
    end

    // Record read back with the requested goal counts applied.
    always_comb begin
        upd_rec = i_rd_data;
        if (!r_ga[8]) begin
            upd_rec.goals_a = r_ga[7:0];
        end
        if (!r_gb[8]) begin
            upd_rec.goals_b = r_gb[7:0];
        end
    end

    // Next state and memory control.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_mid     = r_mid;
        n_ga      = r_ga;
        n_gb      = r_gb;
        n_held    = r_held;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_cv      = r_cv;
        n_slot    = r_slot;
        n_src     = r_src;
        n_wv      = r_wv;
        n_dst     = r_dst;
        n_status  = r_status;
        n_rec     = r_rec;
        o_wr_en   = 1'b0;
        o_wr_addr = r_held[AW-1:0];
        o_wr_data = new_rec;
        o_rd_en   = 1'b0;
        o_rd_addr = idx_m1[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_cmd;
                    n_mid    = i_match_id;
                    n_ga     = i_goals_a;
                    n_gb     = i_goals_b;
                    n_status = STAT_OK;
                    n_rec    = '0;
                    case (i_cmd)
                        CMD_INSERT, CMD_LOAD: begin
                            if (r_held == FULL ||
                                (i_cmd == CMD_INSERT && r_cnt == ID_MAX)) begin
                                n_status = STAT_FULL;
                            end else begin
                                // Append at the top of the table.
                                o_wr_en = 1'b1;
                                n_held  = r_held + 1'b1;
                                n_rec   = new_rec;
                                if (new_id >= r_cnt) begin
                                    n_cnt = (new_id == ID_MAX) ? ID_MAX : new_id + 1'b1;
                                end
                            end
                            n_state = ST_RESP;
                        end
                        CMD_LOOKUP, CMD_UPDATE, CMD_REMOVE: begin
                            n_idx   = r_held;
                            n_cv    = 1'b0;
                            n_state = ST_SRCH;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SRCH: begin
                if (r_cv && i_rd_data.id == r_mid) begin
                    // Newest record with this id found.
                    n_rec = i_rd_data;
                    if (r_cmd == CMD_UPDATE) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_slot;
                        o_wr_data = upd_rec;
                        n_rec     = upd_rec;
                    end
                    if (r_cmd == CMD_REMOVE) begin
                        n_src   = CW'(r_slot) + 1'b1;
                        n_wv    = 1'b0;
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_RESP;
                    end
                end else if (!r_cv && r_idx == '0) begin
                    n_status = STAT_MISS;
                    n_state  = ST_RESP;
                end else if (r_idx != '0) begin
                    // Issue the next older slot; it is compared once its registered read data returns.
                    o_rd_en = 1'b1;
                    n_slot  = idx_m1[AW-1:0];
                    n_cv    = 1'b1;
                    n_idx   = idx_m1;
                end else begin
                    n_cv = 1'b0;
                end
            end

            ST_SHIFT: begin
                // Move each newer record down one slot.
                if (r_wv) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_dst;
                    o_wr_data = i_rd_data;
                end
                if (r_src < r_held) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_src[AW-1:0];
                    n_dst     = src_m1;
                    n_wv      = 1'b1;
                    n_src     = r_src + 1'b1;
                end else begin
                    n_wv = 1'b0;
                    if (!r_wv) begin
                        n_held  = r_held - 1'b1;
                        n_state = ST_RESP;
                    end
                end
            end

            ST_RESP: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
            r_cnt   <= '0;
            r_cv    <= 1'b0;
            r_wv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_cnt   <= n_cnt;
            r_cv    <= n_cv;
            r_wv    <= n_wv;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_mid    <= n_mid;
        r_ga     <= n_ga;
        r_gb     <= n_gb;
        r_idx    <= n_idx;
        r_slot   <= n_slot;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_status <= n_status;
        r_rec    <= n_rec;
    end

    // Record count as reported: low bits only, or zero-extended when narrower.
    generate
        if (CW >= COUNT_W) begin : g_cnt_trunc
            assign count_out = r_held[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign count_out = {{(COUNT_W - CW){1'b0}}, r_held};
        end
    endgenerate

    assign o_stall             = (r_state != ST_IDLE);
    assign o_res_valid         = (r_state == ST_RESP);
    assign o_res.status        = r_status;
    assign o_res.rec           = r_rec;
    assign o_res.entry_count   = count_out;
    assign o_res.next_free_id  = r_cnt;

endmodule

[tb/keyed_record_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_record_table_tb: self-checking bench for the keyed record table
// A short table of directed commands runs first. Random command mixes follow,
// alternating between phases that grow and shrink the table. A closing
// sequence fills the table and saturates the id counter. Every result item is
// compared field by field with a pinned result or the predictor's copy of the
// records. Both handshake sides idle at random, with some stretches kept busy.
// ----------------------------------------------------------------------------
module keyed_record_table_tb;
    import krt_pkg::*;

    localparam int TABLE_DEPTH  = DEF_ENTRIES;
    localparam int RANDOM_ITEMS = 850;
    localparam int PHASE_LEN    = 110;
    localparam int TAIL_CYCLES  = 4 * TABLE_DEPTH;

    // Commands the block treats as no-ops.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // A negative goal count: keep on update, zero on insert or load.
    localparam logic signed [8:0] GOAL_KEEP = 9'sh1FF;
    localparam logic signed [8:0] GOAL_MIN  = 9'sh100;

    // One command of the stimulus, optionally with a typed-in result.
    typedef struct {
        logic [2:0]        cmd;
        logic [15:0]       key;
        logic [7:0]        team_a;
        logic [7:0]        team_b;
        logic signed [8:0] goals_a;
        logic signed [8:0] goals_b;
        bit                pinned;
        t_result           want;
    } t_stim_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [2:0]        i_cmd      = '0;
    logic [15:0]       i_match_id = '0;
    logic [7:0]        i_team_a   = '0;
    logic [7:0]        i_team_b   = '0;
    logic signed [8:0] i_goals_a  = '0;
    logic signed [8:0] i_goals_b  = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic [15:0]       o_out_id;
    logic [7:0]        o_out_team_a;
    logic [7:0]        o_out_team_b;
    logic [7:0]        o_out_goals_a;
    logic [7:0]        o_out_goals_b;
    logic [6:0]        o_entry_count;
    logic [15:0]       o_next_free_id;

    // Predictor state: records in arrival order, oldest in slot 0.
    t_rec        tbl_rec [TABLE_DEPTH];
    int          tbl_held   = 0;
    int          tbl_peak   = 0;
    logic [15:0] tbl_next_id = '0;

    t_result     result_q[$];
    t_stim_row   directed_q[$];
    bit          quiet      = 1'b0;
    int          errors     = 0;
    int          items_sent = 0;
    int          n_ok       = 0;
    int          n_miss     = 0;
    int          n_full     = 0;

    keyed_record_table #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_match_id     (i_match_id),
        .i_team_a       (i_team_a),
        .i_team_b       (i_team_b),
        .i_goals_a      (i_goals_a),
        .i_goals_b      (i_goals_b),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_team_a   (o_out_team_a),
        .o_out_team_b   (o_out_team_b),
        .o_out_goals_a  (o_out_goals_a),
        .o_out_goals_b  (o_out_goals_b),
        .o_entry_count  (o_entry_count),
        .o_next_free_id (o_next_free_id)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result mk_result(logic [1:0] status, logic [15:0] id,
                                          logic [7:0] ta, logic [7:0] tb,
                                          logic [7:0] ga, logic [7:0] gb,
                                          logic [6:0] count, logic [15:0] next_id);
        t_result res;
        res.status       = status;
        res.rec.id       = id;
        res.rec.team_a   = ta;
        res.rec.team_b   = tb;
        res.rec.goals_a  = ga;
        res.rec.goals_b  = gb;
        res.entry_count  = count;
        res.next_free_id = next_id;
        return res;
    endfunction

    // Applies one command to the predicted table and returns its result item.
    function automatic t_result table_apply(logic [2:0] cmd, logic [15:0] key,
                                            logic [7:0] ta, logic [7:0] tb,
                                            logic signed [8:0] ga, logic signed [8:0] gb);
        t_result     res;
        t_rec        r;
        int          slot;
        logic [15:0] new_id;
        res  = '0;
        slot = -1;
        if (cmd == CMD_INSERT || cmd == CMD_LOAD) begin
            new_id = (cmd == CMD_INSERT) ? tbl_next_id : key;
            if (tbl_held >= TABLE_DEPTH || (cmd == CMD_INSERT && tbl_next_id == ID_MAX)) begin
                res.status = STAT_FULL;
            end else begin
                r.id      = new_id;
                r.team_a  = ta;
                r.team_b  = tb;
                r.goals_a = ga[8] ? 8'd0 : ga[7:0];
                r.goals_b = gb[8] ? 8'd0 : gb[7:0];
                tbl_rec[tbl_held] = r;
                tbl_held++;
                if (new_id >= tbl_next_id) begin
                    tbl_next_id = (new_id == ID_MAX) ? ID_MAX : new_id + 16'd1;
                end
                res.rec = r;
            end
        end else if (cmd == CMD_LOOKUP || cmd == CMD_UPDATE || cmd == CMD_REMOVE) begin
            // Newest record with the id wins.
            for (int i = tbl_held - 1; i >= 0; i--) begin
                if (slot < 0 && tbl_rec[i].id == key) slot = i;
            end
            if (slot < 0) begin
                res.status = STAT_MISS;
            end else if (cmd == CMD_LOOKUP) begin
                res.rec = tbl_rec[slot];
            end else if (cmd == CMD_UPDATE) begin
                if (!ga[8]) tbl_rec[slot].goals_a = ga[7:0];
                if (!gb[8]) tbl_rec[slot].goals_b = gb[7:0];
                res.rec = tbl_rec[slot];
            end else begin
                res.rec = tbl_rec[slot];
                for (int i = slot; i < tbl_held - 1; i++) tbl_rec[i] = tbl_rec[i + 1];
                tbl_held--;
            end
        end
        if (tbl_held > tbl_peak) tbl_peak = tbl_held;
        res.entry_count  = 7'(tbl_held);
        res.next_free_id = tbl_next_id;
        return res;
    endfunction

    function automatic t_stim_row row(logic [2:0] cmd, logic [15:0] key,
                                      logic [7:0] ta, logic [7:0] tb,
                                      logic signed [8:0] ga, logic signed [8:0] gb);
        t_stim_row r;
        r.cmd     = cmd;
        r.key     = key;
        r.team_a  = ta;
        r.team_b  = tb;
        r.goals_a = ga;
        r.goals_b = gb;
        r.pinned  = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_stim_row pin(t_stim_row r, t_result want);
        r.pinned = 1'b1;
        r.want   = want;
        return r;
    endfunction

    function automatic int draw_wait();
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Goal counts are mostly plain values, with a share of negative ones.
    function automatic logic signed [8:0] random_goal();
        return {($urandom_range(0, 3) == 0), 8'($urandom)};
    endfunction

    // Mostly an id that is present, otherwise any id.
    function automatic logic [15:0] known_key();
        if (tbl_held > 0 && $urandom_range(0, 9) < 8) begin
            return tbl_rec[$urandom_range(0, tbl_held - 1)].id;
        end
        return 16'($urandom);
    endfunction

    // Random command; growing phases favor inserts, shrinking phases removals.
    function automatic t_stim_row random_row(bit grow);
        t_stim_row r;
        int        w;
        int        ahead;
        r = row(CMD_INSERT, 16'($urandom), 8'($urandom), 8'($urandom),
                random_goal(), random_goal());
        w = $urandom_range(0, 99);
        if (w < (grow ? 40 : 15)) begin
            r.cmd = CMD_INSERT;
        end else if (w < (grow ? 65 : 25)) begin
            r.cmd = CMD_LOAD;
            w     = $urandom_range(0, 9);
            ahead = int'(tbl_next_id) + int'($urandom_range(0, 3));
            if (w < 4) begin
                r.key = known_key();
            end else if (w < 7 && ahead < 16'hF000) begin
                r.key = 16'(ahead);
            end else begin
                r.key = 16'($urandom_range(0, int'(tbl_next_id)));
            end
        end else if (w < (grow ? 77 : 45)) begin
            r.cmd = CMD_LOOKUP;
            r.key = known_key();
        end else if (w < (grow ? 87 : 60)) begin
            r.cmd = CMD_UPDATE;
            r.key = known_key();
        end else if (w < 95) begin
            r.cmd = CMD_REMOVE;
            r.key = known_key();
        end else begin
            r.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end
        return r;
    endfunction

    // Presents one item, waits for acceptance and records its expected result.
    task automatic send_item(t_stim_row r);
        int      n;
        t_result want;
        n = draw_wait();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= r.cmd;
        i_match_id <= r.key;
        i_team_a   <= r.team_a;
        i_team_b   <= r.team_b;
        i_goals_a  <= r.goals_a;
        i_goals_b  <= r.goals_b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        want = table_apply(r.cmd, r.key, r.team_a, r.team_b, r.goals_a, r.goals_b);
        if (r.pinned) want = r.want;
        result_q.push_back(want);
        items_sent++;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: random stall before each item, then wait for it.
    initial begin
        int n;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            n = draw_wait();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    // Compares each accepted result item with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (result_q.size() == 0) begin
                $display("%0t: result item with none expected, status %0h id %0h",
                         $time, o_status, o_out_id);
                errors++;
            end else begin
                want = result_q.pop_front();
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("out_id", want.rec.id, o_out_id);
                check_field("out_team_a", 16'(want.rec.team_a), 16'(o_out_team_a));
                check_field("out_team_b", 16'(want.rec.team_b), 16'(o_out_team_b));
                check_field("out_goals_a", 16'(want.rec.goals_a), 16'(o_out_goals_a));
                check_field("out_goals_b", 16'(want.rec.goals_b), 16'(o_out_goals_b));
                check_field("entry_count", 16'(want.entry_count), 16'(o_entry_count));
                check_field("next_free_id", want.next_free_id, o_next_free_id);
                if (want.status == STAT_OK) n_ok++;
                else if (want.status == STAT_MISS) n_miss++;
                else n_full++;
            end
        end
    end

    // Stimulus: directed table, random phases, then full table and saturated ids.
    initial begin
        bit grow;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table after reset, then the field extremes.
        directed_q.push_back(pin(row(CMD_LOOKUP, 16'h0000, 8'h00, 8'h00, 9'sd0, 9'sd0),
                                 mk_result(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)));
        directed_q.push_back(pin(row(CMD_REMOVE, ID_MAX, 8'hFF, 8'hFF, GOAL_KEEP, GOAL_KEEP),
                                 mk_result(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)));
        directed_q.push_back(pin(row(CMD_UPDATE, 16'h0000, 8'h00, 8'h00, GOAL_KEEP, 9'sd255),
                                 mk_result(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)));
        directed_q.push_back(pin(row(CMD_SPARE_LAST, ID_MAX, 8'hFF, 8'hFF, 9'sd255, GOAL_MIN),
                                 mk_result(STAT_OK, 0, 0, 0, 0, 0, 0, 0)));
        directed_q.push_back(pin(row(CMD_INSERT, ID_MAX, 8'hFF, 8'h00, 9'sd255, GOAL_KEEP),
                                 mk_result(STAT_OK, 0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1, 1)));
        directed_q.push_back(pin(row(CMD_INSERT, 16'h0000, 8'h00, 8'hFF, GOAL_MIN, 9'sd255),
                                 mk_result(STAT_OK, 1, 8'h00, 8'hFF, 8'h00, 8'hFF, 2, 2)));
        directed_q.push_back(pin(row(CMD_LOAD, 16'd100, 8'h5A, 8'hA5, 9'sd0, 9'sd0),
                                 mk_result(STAT_OK, 100, 8'h5A, 8'hA5, 0, 0, 3, 101)));
        directed_q.push_back(pin(row(CMD_LOAD, 16'd5, 8'h01, 8'h02, 9'sd3, 9'sd4),
                                 mk_result(STAT_OK, 5, 8'h01, 8'h02, 3, 4, 4, 101)));
        // A duplicate id: searches must find the newer copy first.
        directed_q.push_back(row(CMD_LOAD, 16'd1, 8'h07, 8'h08, 9'sd9, 9'sd10));
        directed_q.push_back(row(CMD_LOOKUP, 16'd1, 8'h00, 8'h00, 9'sd0, 9'sd0));
        directed_q.push_back(row(CMD_UPDATE, 16'd1, 8'h00, 8'h00, GOAL_KEEP, 9'sd200));
        directed_q.push_back(row(CMD_UPDATE, 16'd0, 8'h00, 8'h00, 9'sd128, GOAL_KEEP));
        directed_q.push_back(row(CMD_UPDATE, 16'd0, 8'hFF, 8'hFF, GOAL_KEEP, GOAL_MIN));
        directed_q.push_back(row(CMD_LOOKUP, 16'd0, 8'h00, 8'h00, 9'sd0, 9'sd0));
        // Removal of the newest, the oldest and a middle record.
        directed_q.push_back(row(CMD_REMOVE, 16'd1, 8'h00, 8'h00, 9'sd0, 9'sd0));
        directed_q.push_back(row(CMD_LOOKUP, 16'd1, 8'h00, 8'h00, 9'sd0, 9'sd0));
        directed_q.push_back(row(CMD_REMOVE, 16'd0, 8'h00, 8'h00, 9'sd0, 9'sd0));
        directed_q.push_back(row(CMD_REMOVE, 16'd100, 8'h00, 8'h00, 9'sd0, 9'sd0));
        directed_q.push_back(row(CMD_LOOKUP, 16'd0, 8'h00, 8'h00, 9'sd0, 9'sd0));
        directed_q.push_back(row(CMD_INSERT, 16'h0000, 8'hAA, 8'h55, 9'sh0AA, 9'sh055));
        directed_q.push_back(row(CMD_SPARE_FIRST, 16'h5555, 8'h55, 8'hAA, 9'sh055, 9'sh0AA));
        directed_q.push_back(row(CMD_SPARE_FIRST + 3'd1, 16'hAAAA, 8'h0F, 8'hF0, 9'sh1FE, 9'sd1));
        directed_q.push_back(row(CMD_UPDATE, 16'd101, 8'h00, 8'h00, 9'sh1FE, 9'sd77));
        directed_q.push_back(row(CMD_LOAD, 16'h0000, 8'h00, 8'h00, 9'sd0, 9'sd0));
        foreach (directed_q[k]) send_item(directed_q[k]);

        // Random phases; every third one runs without idling on either side.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % PHASE_LEN == 0) begin
                if (k != 0) drain_results();
                grow  = ((k / PHASE_LEN) % 2) == 0;
                quiet = ((k / PHASE_LEN) % 3) == 2;
            end
            send_item(random_row(grow));
        end
        quiet = 1'b0;

        // Fill the table, then hit the full and saturated-counter errors.
        while (tbl_held < TABLE_DEPTH) begin
            send_item(row(CMD_INSERT, 16'($urandom), 8'($urandom), 8'($urandom),
                          random_goal(), random_goal()));
        end
        send_item(row(CMD_INSERT, 16'($urandom), 8'hFF, 8'hFF, 9'sd255, 9'sd255));
        send_item(row(CMD_LOAD, 16'($urandom), 8'hFF, 8'hFF, 9'sd255, 9'sd255));
        send_item(row(CMD_LOOKUP, tbl_rec[0].id, 8'h00, 8'h00, 9'sd0, 9'sd0));
        send_item(row(CMD_REMOVE, tbl_rec[0].id, 8'h00, 8'h00, 9'sd0, 9'sd0));
        send_item(row(CMD_REMOVE, tbl_rec[tbl_held - 1].id, 8'h00, 8'h00, 9'sd0, 9'sd0));
        send_item(row(CMD_LOAD, ID_MAX, 8'h12, 8'h34, 9'sd56, 9'sd78));
        send_item(row(CMD_INSERT, 16'h0000, 8'h01, 8'h01, 9'sd1, 9'sd1));
        send_item(row(CMD_LOAD, ID_MAX - 16'd1, 8'h9A, 8'hBC, 9'sd255, GOAL_KEEP));
        send_item(row(CMD_LOOKUP, ID_MAX, 8'h00, 8'h00, 9'sd0, 9'sd0));
        send_item(row(CMD_UPDATE, ID_MAX, 8'h00, 8'h00, 9'sd0, 9'sd255));
        send_item(row(CMD_INSERT, 16'h0000, 8'h02, 8'h02, 9'sd2, 9'sd2));
        send_item(row(CMD_REMOVE, ID_MAX, 8'h00, 8'h00, 9'sd0, 9'sd0));
        i_valid <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d ok, %0d id not found, %0d table full or id saturated.",
                 items_sent, n_ok, n_miss, n_full);
        $display("Table held up to %0d of %0d records; final id counter %0h.",
                 tbl_peak, TABLE_DEPTH, tbl_next_id);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(20_000_000);
        $display("Timeout with %0d result items outstanding.", result_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[keyed_record_table.f]
hw/rtl/krt_pkg.sv
hw/rtl/krt_store.sv
hw/rtl/krt_seq.sv
hw/rtl/keyed_record_table.sv
tb/keyed_record_table_tb.sv
